FILE: sv/kce_pkg.sv
// Shared constants and types for the keypad calculator engine.
// No dependencies; used by kce_mdu and keypad_calculator_engine_unit.
package kce_pkg;

  localparam int W = 48;   // value width
  localparam int F = 16;   // fraction bits

  typedef enum logic [1:0] {
    REQ_DIGIT = 2'd0,
    REQ_OP    = 2'd1,
    REQ_EQ    = 2'd2,
    REQ_CLR   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } kce_cmd_t;

  typedef struct packed {
    logic done;
    logic sat;
  } kce_sts_t;

endpackage

FILE: sv/kce_mdu.sv
// Bit-serial fixed point multiply / divide unit with saturation.
// Depends on kce_pkg.
module kce_mdu (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kce_pkg::kce_cmd_t         cmd_i,
  input  logic [kce_pkg::W-1:0]     a_i,
  input  logic [kce_pkg::W-1:0]     b_i,
  output logic [kce_pkg::W-1:0]     res_o,
  output kce_pkg::kce_sts_t         sts_o
);
  import kce_pkg::*;

  localparam int NB = W + F;
  localparam int CW = $clog2(NB + 1);
  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_RUN  = 2'd1;
  localparam logic [1:0] U_FIN  = 2'd2;

  logic [1:0]     st_q, st_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           neg_q, neg_d, div_q, div_d;
  logic [W-1:0]   xa_q, xa_d;
  logic [NB-1:0]  sh_q, sh_d;
  logic [2*W-1:0] acc_q, acc_d;
  logic [W-1:0]   rem_q, rem_d;
  logic [NB-1:0]  quo_q, quo_d;
  logic [W-1:0]   res_q, res_d;
  logic           sat_q, sat_d, done_q, done_d;

  logic [W-1:0]   mag_a, mag_b;
  logic [W:0]     msum, r2, rdiff;
  logic           ge, last;
  logic [W-1:0]   lo, lim;
  logic           hi;

  assign mag_a = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign mag_b = b_i[W-1] ? (~b_i + W'(1)) : b_i;

  assign msum  = {1'b0, acc_q[2*W-1:W]} + (sh_q[0] ? {1'b0, xa_q} : {(W+1){1'b0}});
  assign r2    = {rem_q, sh_q[NB-1]};
  assign rdiff = r2 - {1'b0, xa_q};
  assign ge    = (r2 >= {1'b0, xa_q});
  assign last  = div_q ? (cnt_q == CW'(NB - 1)) : (cnt_q == CW'(W - 1));

  always_comb begin
    // product P >> F, or quotient; overflow if anything sits above W bits
    if (div_q) begin
      lo = quo_q[W-1:0];
      hi = |quo_q[NB-1:W];
    end else begin
      lo = acc_q[F+W-1:F];
      hi = |acc_q[2*W-1:F+W];
    end
    lim = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  end

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    div_d  = div_q;
    xa_d   = xa_q;
    sh_d   = sh_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    res_d  = res_q;
    sat_d  = sat_q;
    done_d = 1'b0;
    case (st_q)
      U_IDLE: begin
        if (cmd_i.start) begin
          st_d  = U_RUN;
          cnt_d = '0;
          neg_d = a_i[W-1] ^ b_i[W-1];
          div_d = cmd_i.is_div;
          acc_d = '0;
          rem_d = '0;
          quo_d = '0;
          if (cmd_i.is_div) begin
            xa_d = mag_b;
            sh_d = {mag_a, {F{1'b0}}};
          end else begin
            xa_d = mag_a;
            sh_d = NB'(mag_b);
          end
        end
      end
      U_RUN: begin
        cnt_d = cnt_q + CW'(1);
        if (div_q) begin
          rem_d = ge ? rdiff[W-1:0] : r2[W-1:0];
          quo_d = {quo_q[NB-2:0], ge};
          sh_d  = {sh_q[NB-2:0], 1'b0};
        end else begin
          acc_d = {msum, acc_q[W-1:1]};
          sh_d  = {1'b0, sh_q[NB-1:1]};
        end
        if (last) st_d = U_FIN;
      end
      U_FIN: begin
        if (hi || (lo > lim)) begin
          sat_d = 1'b1;
          res_d = neg_q ? (~lim + W'(1)) : lim;
        end else begin
          sat_d = 1'b0;
          res_d = neg_q ? (~lo + W'(1)) : lo;
        end
        done_d = 1'b1;
        st_d   = U_IDLE;
      end
      default: st_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= U_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    div_q <= div_d;
    xa_q  <= xa_d;
    sh_q  <= sh_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    res_q <= res_d;
    sat_q <= sat_d;
  end

  assign res_o     = res_q;
  assign sts_o.done = done_q;
  assign sts_o.sat  = sat_q;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> st_q == U_IDLE) else $error("mdu started while busy");
  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == U_FIN |=> done_q && st_q == U_IDLE) else $error("mdu finish lost");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == U_RUN |-> cnt_q < CW'(NB)) else $error("mdu count overrun");
`endif

endmodule

FILE: sv/keypad_calculator_engine_unit.sv
// Top level of the keypad calculator engine: key decode, state, add/sub, output word.
// Depends on kce_pkg and kce_mdu.
//
// One key word in, one display word out. A digit that starts a new entry, clear,
// add, subtract and operator or equals keys that apply nothing pass from S_IDLE
// through S_OUT to the output register; a digit that appends to the entry passes
// S_WAIT before S_OUT. A pending multiply, or a divide by a nonzero value, waits in
// S_WAIT for the bit-serial multiply/divide unit, which retires one bit per cycle. A new key is
// taken once the previous word has reached the output register, even while that
// word still waits there.
module keypad_calculator_engine_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic [3:0]                  digit_i,
  input  logic [1:0]                  op_code_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [kce_pkg::W-1:0] display_value_o,
  output logic                        is_whole_o,
  output logic                        saturated_o
);
  import kce_pkg::*;

  localparam int XW = W + 4;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WAIT = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;
  localparam logic signed [XW-1:0] VMAX_X = {5'b00000, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] VMIN_X = {5'b11111, {(W-1){1'b0}}};
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // returns {overflow, clamped sum}
  function automatic logic [W:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) sat_add = {1'b1, s[W] ? VMIN : VMAX};
    else                sat_add = {1'b0, s[W-1:0]};
  endfunction

  // returns {overflow, clamped difference}
  function automatic logic [W:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) sat_sub = {1'b1, s[W] ? VMIN : VMAX};
    else                sat_sub = {1'b0, s[W-1:0]};
  endfunction

  logic [1:0]   st_q, st_d;
  logic [W-1:0] cur_q, cur_d, sto_q, sto_d;
  logic         pv_q, pv_d, sne_q, sne_d, sat_q, sat_d;
  logic [1:0]   pop_q, pop_d, req_q, req_d, op_q, op_d;
  logic         ov_q;
  logic [W-1:0] dv_q;
  logic [W-1:0] outv_q;
  logic         outw_q, outs_q;

  kce_cmd_t     cmd;
  kce_sts_t     sts;
  logic [W-1:0] mdu_res;

  logic         acc_in, apply, slot_free;
  logic signed [XW-1:0] cw, tw, dvw;
  logic [W-1:0] dv, t10;
  logic         dsat, tsat;
  logic [W:0]   addr, subr, dgr;

  assign acc_in    = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != S_IDLE);
  assign slot_free = !out_valid_o || !out_stall_i;
  assign apply     = pv_q && !sne_q;

  // digit path
  always_comb begin
    dvw  = XW'(digit_i) <<< F;
    dsat = dvw > VMAX_X;
    dv   = dsat ? VMAX : dvw[W-1:0];
    cw   = {{4{cur_q[W-1]}}, cur_q};
    tw   = (cw <<< 3) + (cw <<< 1);
    tsat = (tw > VMAX_X) || (tw < VMIN_X);
    t10  = (tw > VMAX_X) ? VMAX : ((tw < VMIN_X) ? VMIN : tw[W-1:0]);
  end

  assign addr = sat_add(sto_q, cur_q);
  assign subr = sat_sub(sto_q, cur_q);
  assign dgr  = sat_add(dv_q, t10);

  always_comb begin
    st_d  = st_q;
    cur_d = cur_q;
    sto_d = sto_q;
    pv_d  = pv_q;
    sne_d = sne_q;
    pop_d = pop_q;
    sat_d = sat_q;
    req_d = req_q;
    op_d  = op_q;
    cmd   = '0;
    case (st_q)
      S_IDLE: begin
        if (acc_in) begin
          req_d = req_type_i;
          op_d  = op_code_i;
          sat_d = 1'b0;
          st_d  = S_OUT;
          case (req_type_i)
            REQ_DIGIT: begin
              if (sne_q) begin
                cur_d = dv;
                sat_d = dsat;
                sne_d = 1'b0;
              end else begin
                // append finishes next cycle through dv_q / ov_q
                st_d = S_WAIT;
              end
            end
            REQ_OP, REQ_EQ: begin
              if (req_type_i == REQ_OP || pv_q) begin
                if (apply && (pop_q == OP_MUL || (pop_q == OP_DIV && cur_q != '0))) begin
                  cmd.start  = 1'b1;
                  cmd.is_div = (pop_q == OP_DIV);
                  st_d       = S_WAIT;
                end else begin
                  if (apply && pop_q == OP_ADD) begin
                    cur_d = addr[W-1:0];
                    sat_d = addr[W];
                  end else if (apply && pop_q == OP_SUB) begin
                    cur_d = subr[W-1:0];
                    sat_d = subr[W];
                  end
                  sto_d = cur_d;
                  sne_d = 1'b1;
                  pv_d  = (req_type_i == REQ_OP);
                  pop_d = (req_type_i == REQ_OP) ? op_code_i : OP_ADD;
                end
              end
            end
            REQ_CLR: begin
              cur_d = '0;
              sto_d = '0;
              pv_d  = 1'b0;
              pop_d = OP_ADD;
              sne_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_WAIT: begin
        if (req_q == REQ_DIGIT) begin
          cur_d = dgr[W-1:0];
          sat_d = ov_q | dgr[W];
          st_d  = S_OUT;
        end else if (sts.done) begin
          cur_d = mdu_res;
          sat_d = sts.sat;
          sto_d = mdu_res;
          sne_d = 1'b1;
          pv_d  = (req_q == REQ_OP);
          pop_d = (req_q == REQ_OP) ? op_q : OP_ADD;
          st_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  kce_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .a_i    (sto_q),
    .b_i    (cur_q),
    .res_o  (mdu_res),
    .sts_o  (sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cur_q       <= '0;
      sto_q       <= '0;
      pv_q        <= 1'b0;
      sne_q       <= 1'b1;
      pop_q       <= OP_ADD;
      sat_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      st_q  <= st_d;
      cur_q <= cur_d;
      sto_q <= sto_d;
      pv_q  <= pv_d;
      sne_q <= sne_d;
      pop_q <= pop_d;
      sat_q <= sat_d;
      if (st_q == S_OUT && slot_free) out_valid_o <= 1'b1;
      else if (!out_stall_i)          out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    op_q  <= op_d;
    if (acc_in) begin
      dv_q <= dv;
      ov_q <= dsat | tsat;
    end
    if (st_q == S_OUT && slot_free) begin
      outv_q <= cur_q;
      outw_q <= (cur_q[F-1:0] == '0);
      outs_q <= sat_q;
    end
  end

  assign display_value_o = outv_q;
  assign is_whole_o      = outw_q;
  assign saturated_o     = outs_q;

`ifndef SYNTH
  a_start_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> acc_in) else $error("mdu start without accepted word");
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.done |-> st_q == S_WAIT) else $error("mdu result with nobody waiting");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_OUT && slot_free |=> out_valid_o && st_q == S_IDLE)
    else $error("output word not loaded");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in && req_type_i == REQ_CLR |=> cur_q == '0 && sne_q && !pv_q)
    else $error("clear did not reset state");
`endif

endmodule
